/* hw/rtl/mer_pkg.sv */
package mer_pkg;

   localparam int unsigned MER_RADIUS_BITS = 10;
   localparam int unsigned MER_COORD_BITS  = 12;

   localparam int unsigned MER_CSR_IDX_W = 2;
   localparam logic [MER_CSR_IDX_W-1:0] MER_CSR_CENTER_X = 2'd0;
   localparam logic [MER_CSR_IDX_W-1:0] MER_CSR_CENTER_Y = 2'd1;
   localparam logic [MER_CSR_IDX_W-1:0] MER_CSR_RADIUS_X = 2'd2;
   localparam logic [MER_CSR_IDX_W-1:0] MER_CSR_RADIUS_Y = 2'd3;

   localparam int unsigned MER_MUL_W = 3;
   localparam logic [MER_MUL_W-1:0] MER_MUL_RX_RX   = 3'd0;
   localparam logic [MER_MUL_W-1:0] MER_MUL_RY_RY   = 3'd1;
   localparam logic [MER_MUL_W-1:0] MER_MUL_RX2_RY  = 3'd2;
   localparam logic [MER_MUL_W-1:0] MER_MUL_TX_TX   = 3'd3;
   localparam logic [MER_MUL_W-1:0] MER_MUL_TY_TY   = 3'd4;
   localparam logic [MER_MUL_W-1:0] MER_MUL_RY2_TMP = 3'd5;
   localparam logic [MER_MUL_W-1:0] MER_MUL_RX2_TMP = 3'd6;
   localparam logic [MER_MUL_W-1:0] MER_MUL_RX2_RY2 = 3'd7;

   localparam int unsigned MER_ACT_W = 4;
   localparam logic [MER_ACT_W-1:0] MER_ACT_NONE     = 4'd0;
   localparam logic [MER_ACT_W-1:0] MER_ACT_SET_RX2  = 4'd1;
   localparam logic [MER_ACT_W-1:0] MER_ACT_SET_RY2  = 4'd2;
   localparam logic [MER_ACT_W-1:0] MER_ACT_INIT_R1  = 4'd3;
   localparam logic [MER_ACT_W-1:0] MER_ACT_SET_TMP  = 4'd4;
   localparam logic [MER_ACT_W-1:0] MER_ACT_ACC_LOAD = 4'd5;
   localparam logic [MER_ACT_W-1:0] MER_ACT_ACC_ADD4 = 4'd6;
   localparam logic [MER_ACT_W-1:0] MER_ACT_ACC_SUB4 = 4'd7;
   localparam logic [MER_ACT_W-1:0] MER_ACT_TRUNC    = 4'd8;
   localparam logic [MER_ACT_W-1:0] MER_ACT_R1A      = 4'd9;
   localparam logic [MER_ACT_W-1:0] MER_ACT_R1B      = 4'd10;
   localparam logic [MER_ACT_W-1:0] MER_ACT_R2A      = 4'd11;
   localparam logic [MER_ACT_W-1:0] MER_ACT_R2B      = 4'd12;
   localparam logic [MER_ACT_W-1:0] MER_ACT_EMIT     = 4'd13;

   typedef struct packed {
      logic                 load;
      logic [MER_MUL_W-1:0] mul_sel;
      logic [MER_ACT_W-1:0] act;
   } mer_cmd_type;

   typedef struct packed {
      logic d_neg;
      logic d_pos;
      logic sx_lt_sy;
      logic oy_zero;
   } mer_status_type;

endpackage

/* hw/rtl/mer_ctrl.sv */
module mer_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_restart,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  mer_pkg::mer_status_type status,
   output mer_pkg::mer_cmd_type    cmd
);

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_M1    = 5'd1;
   localparam logic [4:0] ST_M2    = 5'd2;
   localparam logic [4:0] ST_M3    = 5'd3;
   localparam logic [4:0] ST_M4    = 5'd4;
   localparam logic [4:0] ST_E1    = 5'd5;
   localparam logic [4:0] ST_E2    = 5'd6;
   localparam logic [4:0] ST_E3    = 5'd7;
   localparam logic [4:0] ST_E4    = 5'd8;
   localparam logic [4:0] ST_E5    = 5'd9;
   localparam logic [4:0] ST_E6    = 5'd10;
   localparam logic [4:0] ST_TRUNC = 5'd11;
   localparam logic [4:0] ST_R1A   = 5'd12;
   localparam logic [4:0] ST_R1B   = 5'd13;
   localparam logic [4:0] ST_R2A   = 5'd14;
   localparam logic [4:0] ST_R2B   = 5'd15;
   localparam logic [4:0] ST_EMIT  = 5'd16;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_R1   = 2'd1;
   localparam logic [1:0] PH_R2   = 2'd2;

   logic [4:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       emit;

   assign req_ready = (state_ff == ST_IDLE) & ~reset;
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid & req_ready;
   assign emit      = (state_ff == ST_EMIT) & (~rsp_valid_ff | rsp_ready);

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      cmd.load    = 1'b0;
      cmd.mul_sel = mer_pkg::MER_MUL_RX_RX;
      cmd.act     = mer_pkg::MER_ACT_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_restart) begin
                  cmd.load = 1'b1;
                  phase_in = PH_R1;
                  state_in = ST_M1;
               end else begin
                  case (phase_ff)
                     PH_R1: begin
                        if (status.sx_lt_sy) begin
                           state_in = ST_R1A;
                        end else begin
                           phase_in = PH_R2;
                           state_in = ST_E1;
                        end
                     end
                     PH_R2:   state_in = ST_R2A;
                     default: state_in = ST_IDLE;
                  endcase
               end
            end
         end
         ST_M1: begin
            cmd.mul_sel = mer_pkg::MER_MUL_RX_RX;
            state_in    = ST_M2;
         end
         ST_M2: begin
            cmd.act     = mer_pkg::MER_ACT_SET_RX2;
            cmd.mul_sel = mer_pkg::MER_MUL_RY_RY;
            state_in    = ST_M3;
         end
         ST_M3: begin
            cmd.act     = mer_pkg::MER_ACT_SET_RY2;
            cmd.mul_sel = mer_pkg::MER_MUL_RX2_RY;
            state_in    = ST_M4;
         end
         ST_M4: begin
            cmd.act  = mer_pkg::MER_ACT_INIT_R1;
            state_in = ST_TRUNC;
         end
         ST_E1: begin
            cmd.mul_sel = mer_pkg::MER_MUL_TX_TX;
            state_in    = ST_E2;
         end
         ST_E2: begin
            cmd.act     = mer_pkg::MER_ACT_SET_TMP;
            cmd.mul_sel = mer_pkg::MER_MUL_TY_TY;
            state_in    = ST_E3;
         end
         ST_E3: begin
            cmd.act     = mer_pkg::MER_ACT_SET_TMP;
            cmd.mul_sel = mer_pkg::MER_MUL_RY2_TMP;
            state_in    = ST_E4;
         end
         ST_E4: begin
            cmd.act     = mer_pkg::MER_ACT_ACC_LOAD;
            cmd.mul_sel = mer_pkg::MER_MUL_RX2_TMP;
            state_in    = ST_E5;
         end
         ST_E5: begin
            cmd.act     = mer_pkg::MER_ACT_ACC_ADD4;
            cmd.mul_sel = mer_pkg::MER_MUL_RX2_RY2;
            state_in    = ST_E6;
         end
         ST_E6: begin
            cmd.act  = mer_pkg::MER_ACT_ACC_SUB4;
            state_in = ST_TRUNC;
         end
         ST_TRUNC: begin
            cmd.act  = mer_pkg::MER_ACT_TRUNC;
            state_in = (phase_ff == PH_R2) ? ST_R2A : ST_EMIT;
         end
         ST_R1A: begin
            cmd.act  = mer_pkg::MER_ACT_R1A;
            state_in = ST_R1B;
         end
         ST_R1B: begin
            cmd.act  = mer_pkg::MER_ACT_R1B;
            state_in = ST_EMIT;
         end
         ST_R2A: begin
            cmd.act  = mer_pkg::MER_ACT_R2A;
            state_in = ST_R2B;
         end
         ST_R2B: begin
            cmd.act  = mer_pkg::MER_ACT_R2B;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit) begin
               cmd.act  = mer_pkg::MER_ACT_EMIT;
               state_in = ST_IDLE;
               if (status.oy_zero) begin
                  phase_in = PH_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hw/rtl/mer_datapath.sv */
module mer_datapath #(
   parameter int unsigned RADIUS_BITS = mer_pkg::MER_RADIUS_BITS,
   parameter int unsigned COORD_BITS  = mer_pkg::MER_COORD_BITS,
   localparam int unsigned CSR_W = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS,
   localparam int unsigned OUT_W = COORD_BITS + 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [mer_pkg::MER_CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_W-1:0]                    csr_wdata,
   input  mer_pkg::mer_cmd_type                 cmd,
   output mer_pkg::mer_status_type              status,
   output logic signed [OUT_W-1:0]             rsp_east_x,
   output logic signed [OUT_W-1:0]             rsp_west_x,
   output logic signed [OUT_W-1:0]             rsp_north_y,
   output logic signed [OUT_W-1:0]             rsp_south_y,
   output logic                                rsp_last_point
);

   localparam int unsigned SQ_W    = 2 * RADIUS_BITS;
   localparam int unsigned TMP_W   = 2 * RADIUS_BITS + 2;
   localparam int unsigned PROD_W  = SQ_W + TMP_W;
   localparam int unsigned SLOPE_W = 3 * RADIUS_BITS + 3;
   localparam int unsigned DEC_W   = 4 * RADIUS_BITS + 8;

   logic signed [COORD_BITS-1:0]  cfg_cx_ff, cfg_cy_ff;
   logic [RADIUS_BITS-1:0]        cfg_rx_ff, cfg_ry_ff;

   logic signed [COORD_BITS-1:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic [RADIUS_BITS-1:0]        rx_ff, rx_in, ox_ff, ox_in, oy_ff, oy_in;
   logic [SQ_W-1:0]               rx2_ff, rx2_in, ry2_ff, ry2_in;
   logic [TMP_W-1:0]              tmp_ff, tmp_in;
   logic [PROD_W-1:0]             prod_ff, prod_in;
   logic signed [SLOPE_W-1:0]     sx_ff, sx_in, sy_ff, sy_in;
   logic signed [DEC_W-1:0]       d_ff, d_in, acc_ff, acc_in;
   logic signed [OUT_W-1:0]       east_ff, east_in, west_ff, west_in;
   logic signed [OUT_W-1:0]       north_ff, north_in, south_ff, south_in;
   logic                          last_ff, last_in;

   logic [SQ_W-1:0]               mul_a;
   logic [TMP_W-1:0]              mul_b;
   logic [RADIUS_BITS:0]          tx;
   logic [RADIUS_BITS-1:0]        ty;
   logic signed [SLOPE_W-1:0]     rx2x2_s, ry2x2_s;
   logic signed [DEC_W-1:0]       prod_d, rx2_d, ry2_d, sx_d, sy_d, trunc_q;
   logic signed [OUT_W-1:0]       cx_o, cy_o, ox_o, oy_o;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_cx_ff <= '0;
         cfg_cy_ff <= '0;
         cfg_rx_ff <= '0;
         cfg_ry_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            mer_pkg::MER_CSR_CENTER_X: cfg_cx_ff <= csr_wdata[COORD_BITS-1:0];
            mer_pkg::MER_CSR_CENTER_Y: cfg_cy_ff <= csr_wdata[COORD_BITS-1:0];
            mer_pkg::MER_CSR_RADIUS_X: cfg_rx_ff <= csr_wdata[RADIUS_BITS-1:0];
            mer_pkg::MER_CSR_RADIUS_Y: cfg_ry_ff <= csr_wdata[RADIUS_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign tx = {ox_ff, 1'b1};
   assign ty = oy_ff - RADIUS_BITS'(1);

   always_comb begin
      unique case (cmd.mul_sel)
         mer_pkg::MER_MUL_RX_RX: begin
            mul_a = SQ_W'(rx_ff);
            mul_b = TMP_W'(rx_ff);
         end
         mer_pkg::MER_MUL_RY_RY: begin
            mul_a = SQ_W'(oy_ff);
            mul_b = TMP_W'(oy_ff);
         end
         mer_pkg::MER_MUL_RX2_RY: begin
            mul_a = rx2_ff;
            mul_b = TMP_W'(oy_ff);
         end
         mer_pkg::MER_MUL_TX_TX: begin
            mul_a = SQ_W'(tx);
            mul_b = TMP_W'(tx);
         end
         mer_pkg::MER_MUL_TY_TY: begin
            mul_a = SQ_W'(ty);
            mul_b = TMP_W'(ty);
         end
         mer_pkg::MER_MUL_RY2_TMP: begin
            mul_a = ry2_ff;
            mul_b = tmp_ff;
         end
         mer_pkg::MER_MUL_RX2_TMP: begin
            mul_a = rx2_ff;
            mul_b = tmp_ff;
         end
         mer_pkg::MER_MUL_RX2_RY2: begin
            mul_a = rx2_ff;
            mul_b = TMP_W'(ry2_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = PROD_W'(mul_a * mul_b);

   assign rx2x2_s = SLOPE_W'({rx2_ff, 1'b0});
   assign ry2x2_s = SLOPE_W'({ry2_ff, 1'b0});
   assign prod_d  = DEC_W'(prod_ff);
   assign rx2_d   = DEC_W'(rx2_ff);
   assign ry2_d   = DEC_W'(ry2_ff);
   assign sx_d    = DEC_W'(sx_ff);
   assign sy_d    = DEC_W'(sy_ff);
   // quarter units back to units, rounding toward zero
   assign trunc_q = acc_ff[DEC_W-1] ? ((acc_ff + DEC_W'(3)) >>> 2) : (acc_ff >>> 2);

   assign cx_o = OUT_W'(cx_ff);
   assign cy_o = OUT_W'(cy_ff);
   assign ox_o = OUT_W'(ox_ff);
   assign oy_o = OUT_W'(oy_ff);

   assign status.d_neg    = d_ff[DEC_W-1];
   assign status.d_pos    = ~d_ff[DEC_W-1] & (d_ff != '0);
   assign status.sx_lt_sy = (sx_ff < sy_ff);
   assign status.oy_zero  = (oy_ff == '0);

   always_comb begin
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      rx_in    = rx_ff;
      ox_in    = ox_ff;
      oy_in    = oy_ff;
      rx2_in   = rx2_ff;
      ry2_in   = ry2_ff;
      tmp_in   = tmp_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      d_in     = d_ff;
      acc_in   = acc_ff;
      east_in  = east_ff;
      west_in  = west_ff;
      north_in = north_ff;
      south_in = south_ff;
      last_in  = last_ff;
      if (cmd.load) begin
         cx_in = cfg_cx_ff;
         cy_in = cfg_cy_ff;
         rx_in = cfg_rx_ff;
         ox_in = '0;
         oy_in = cfg_ry_ff;
         sx_in = '0;
      end
      case (cmd.act)
         mer_pkg::MER_ACT_SET_RX2: rx2_in = prod_ff[SQ_W-1:0];
         mer_pkg::MER_ACT_SET_RY2: ry2_in = prod_ff[SQ_W-1:0];
         mer_pkg::MER_ACT_INIT_R1: begin
            sy_in  = SLOPE_W'({prod_ff, 1'b0});
            acc_in = (ry2_d <<< 2) - (prod_d <<< 2) + rx2_d;
         end
         mer_pkg::MER_ACT_SET_TMP:  tmp_in = prod_ff[TMP_W-1:0];
         mer_pkg::MER_ACT_ACC_LOAD: acc_in = prod_d;
         mer_pkg::MER_ACT_ACC_ADD4: acc_in = acc_ff + (prod_d <<< 2);
         mer_pkg::MER_ACT_ACC_SUB4: acc_in = acc_ff - (prod_d <<< 2);
         mer_pkg::MER_ACT_TRUNC:    d_in   = trunc_q;
         mer_pkg::MER_ACT_R1A: begin
            ox_in = ox_ff + RADIUS_BITS'(1);
            sx_in = sx_ff + ry2x2_s;
            if (!status.d_neg) begin
               oy_in = oy_ff - RADIUS_BITS'(1);
               sy_in = sy_ff - rx2x2_s;
            end
         end
         mer_pkg::MER_ACT_R1B: begin
            if (status.d_neg) begin
               d_in = d_ff + ry2_d + sx_d;
            end else begin
               d_in = d_ff + ry2_d + sx_d - sy_d;
            end
         end
         mer_pkg::MER_ACT_R2A: begin
            oy_in = oy_ff - RADIUS_BITS'(1);
            sy_in = sy_ff - rx2x2_s;
            if (!status.d_pos) begin
               ox_in = ox_ff + RADIUS_BITS'(1);
               sx_in = sx_ff + ry2x2_s;
            end
         end
         mer_pkg::MER_ACT_R2B: begin
            if (status.d_pos) begin
               d_in = d_ff + rx2_d - sy_d;
            end else begin
               d_in = d_ff + rx2_d + sx_d - sy_d;
            end
         end
         mer_pkg::MER_ACT_EMIT: begin
            east_in  = cx_o + ox_o;
            west_in  = cx_o - ox_o;
            north_in = cy_o + oy_o;
            south_in = cy_o - oy_o;
            last_in  = status.oy_zero;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      rx_ff    <= rx_in;
      ox_ff    <= ox_in;
      oy_ff    <= oy_in;
      rx2_ff   <= rx2_in;
      ry2_ff   <= ry2_in;
      tmp_ff   <= tmp_in;
      prod_ff  <= prod_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      d_ff     <= d_in;
      acc_ff   <= acc_in;
      east_ff  <= east_in;
      west_ff  <= west_in;
      north_ff <= north_in;
      south_ff <= south_in;
      last_ff  <= last_in;
   end

   assign rsp_east_x     = east_ff;
   assign rsp_west_x     = west_ff;
   assign rsp_north_y    = north_ff;
   assign rsp_south_y    = south_ff;
   assign rsp_last_point = last_ff;

endmodule

/* hw/rtl/midpoint_ellipse_rasterizer.sv */
// Step item: slope update, decision update, output.
// Restart item: three chained multiplies on one shared multiplier, rounding, output.
// First region-2 step: five products for the new decision on the same multiplier, rounding, then the step.
// No new item is taken until the last one reaches its output; a step while no ellipse is active gives no result.
// The next item is taken while the last result waits; a held result stalls only the one after.
// Reset: synchronous, active high; clears the controller, output valid and config registers.
module midpoint_ellipse_rasterizer #(
   parameter int unsigned RADIUS_BITS = mer_pkg::MER_RADIUS_BITS,
   parameter int unsigned COORD_BITS  = mer_pkg::MER_COORD_BITS,
   localparam int unsigned CSR_W = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS,
   localparam int unsigned OUT_W = COORD_BITS + 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_restart,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [OUT_W-1:0]           rsp_east_x,
   output logic signed [OUT_W-1:0]           rsp_west_x,
   output logic signed [OUT_W-1:0]           rsp_north_y,
   output logic signed [OUT_W-1:0]           rsp_south_y,
   output logic                              rsp_last_point,
   input  logic                              csr_wr_en,
   input  logic [mer_pkg::MER_CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]                  csr_wdata
);

   mer_pkg::mer_cmd_type    cmd;
   mer_pkg::mer_status_type status;

   mer_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_restart (req_restart),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .status      (status),
      .cmd         (cmd)
   );

   mer_datapath #(
      .RADIUS_BITS (RADIUS_BITS),
      .COORD_BITS  (COORD_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cmd            (cmd),
      .status         (status),
      .rsp_east_x     (rsp_east_x),
      .rsp_west_x     (rsp_west_x),
      .rsp_north_y    (rsp_north_y),
      .rsp_south_y    (rsp_south_y),
      .rsp_last_point (rsp_last_point)
   );

endmodule

/* hw/rtl/mer_checker.sv */
module mer_checker #(
   parameter int unsigned COORD_BITS = mer_pkg::MER_COORD_BITS,
   localparam int unsigned OUT_W = COORD_BITS + 1
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    req_restart,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [OUT_W-1:0] rsp_east_x,
   input logic signed [OUT_W-1:0] rsp_west_x,
   input logic signed [OUT_W-1:0] rsp_north_y,
   input logic signed [OUT_W-1:0] rsp_south_y,
   input logic                    rsp_last_point
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_east_x) && $stable(rsp_west_x)
         && $stable(rsp_north_y) && $stable(rsp_south_y) && $stable(rsp_last_point))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a restart runs its multiplies before its first point is shown
   a_restart_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_restart && !rsp_valid |=> !rsp_valid)
      else $error("restart point too early");

   a_last_on_axis: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_point |-> rsp_north_y == rsp_south_y)
      else $error("last point off the horizontal axis");

endmodule

bind midpoint_ellipse_rasterizer mer_checker #(.COORD_BITS(COORD_BITS)) u_mer_checker (.*);
